// ===== rtl/core/alm_pkg.sv =====
// Shared types and constants for the array linked list manager.
package alm_pkg;

    localparam int SLOTS_DEF      = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int ACT_W    = 3;
    localparam int SLOT_W   = 6;
    localparam int STAT_W   = 3;
    localparam int IN_VAL_W = 32;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_BACK = 3'd0,
        ACT_PUT_AFTER = 3'd1,
        ACT_DROP_HEAD = 3'd2,
        ACT_DROP_TAIL = 3'd3,
        ACT_DROP_SLOT = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_MISSING = 3'd2,
        ST_CORRUPT = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_BADIDX  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CHK,
        S_RDA,
        S_RDB,
        S_WR1,
        S_WR2,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/alm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module alm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/array_linked_list_manager.sv =====
// Top level of the array based doubly linked list manager with a free list.
//
// The block keeps a doubly linked list of value slots in four RAMs (values,
// next links, prev links and used marks) plus head, tail and free pointers.
// Slot 0 is the null sentinel. One input word carries an action, a target
// slot and a value; each input word yields exactly one output word with a
// status, a result slot and the head, tail and free pointers after the action.
//
// Both channels use valid and ready. The input channel is ready only while
// the sequencer is idle. A small sequencer walks each action through the
// RAM read and write ports: a check state, one or two read states (the
// read data is registered), two write states, and a final state that hands
// the result to the output register; an action that fails skips to that
// final state. The order of the states is set by the single read and write
// port of each link RAM.
//
// After reset a clearing pass over every slot writes the initial free chain,
// clears the prev links and values and marks only the sentinel used; the
// block accepts no word meanwhile. The output register holds a finished word
// until it is taken; the next input word may be accepted while it waits, and
// the sequencer stalls at the end of that action until the output slot is free.
module array_linked_list_manager #(
    parameter int SLOTS      = alm_pkg::SLOTS_DEF,
    parameter int VALUE_BITS = alm_pkg::VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [alm_pkg::ACT_W-1:0]   i_action,
    input  logic [alm_pkg::SLOT_W-1:0]  i_slot,
    input  logic signed [alm_pkg::IN_VAL_W-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [alm_pkg::STAT_W-1:0]  o_status,
    output logic [alm_pkg::SLOT_W-1:0]  o_result_slot,
    output logic [alm_pkg::SLOT_W-1:0]  o_head_slot,
    output logic [alm_pkg::SLOT_W-1:0]  o_tail_slot,
    output logic [alm_pkg::SLOT_W-1:0]  o_free_slot
);

    import alm_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int EW = SLOT_W + IW;

    // Control state.
    t_state          r_state, n_state;
    logic [IW-1:0]   r_cnt, n_cnt;
    logic [IW-1:0]   r_head, n_head;
    logic [IW-1:0]   r_tail, n_tail;
    logic [IW-1:0]   r_free, n_free;
    logic            r_ovalid, n_ovalid;

    // Per-action working registers.
    t_action         r_act, n_act;
    logic [IW-1:0]   r_slot, n_slot;
    logic            r_bad, n_bad;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [IW-1:0]   r_a, n_a;
    logic [IW-1:0]   r_n, n_n;
    logic [IW-1:0]   r_p, n_p;
    logic [IW-1:0]   r_nf, n_nf;
    t_status         r_st, n_st;
    logic [IW-1:0]   r_res, n_res;

    // Output payload registers.
    logic [STAT_W-1:0] r_ostat, n_ostat;
    logic [SLOT_W-1:0] r_ores, n_ores;
    logic [SLOT_W-1:0] r_ohead, n_ohead;
    logic [SLOT_W-1:0] r_otail, n_otail;
    logic [SLOT_W-1:0] r_ofree, n_ofree;

    // RAM ports.
    logic [IW-1:0]          w_raddr;
    logic                   w_next_we, w_prev_we, w_used_we, w_val_we;
    logic [IW-1:0]          w_next_wa, w_prev_wa, w_used_wa, w_val_wa;
    logic [IW-1:0]          w_next_wd, w_prev_wd;
    logic                   w_used_wd;
    logic [VALUE_BITS-1:0]  w_val_wd;
    logic [IW-1:0]          w_next_rd, w_prev_rd;
    logic                   w_used_rd;

    // Input conversions: the slot port is fixed at six bits, the index
    // width follows SLOTS.
    logic [EW-1:0]          w_slot_ext;
    logic [63:0]            w_val_ext;
    logic                   w_take_out;

    // Pointer conversions to the fixed six bit result ports.
    logic [EW-1:0]          w_head_ext, w_tail_ext, w_free_ext, w_res_ext;

    assign w_slot_ext = {{IW{1'b0}}, i_slot};
    assign w_val_ext  = {32'b0, i_value};
    assign w_take_out = !r_ovalid || i_ready;

    assign w_head_ext = {{SLOT_W{1'b0}}, n_head};
    assign w_tail_ext = {{SLOT_W{1'b0}}, n_tail};
    assign w_free_ext = {{SLOT_W{1'b0}}, n_free};
    assign w_res_ext  = {{SLOT_W{1'b0}}, r_res};

    alm_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_next_we),
        .i_waddr (w_next_wa),
        .i_wdata (w_next_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_next_rd)
    );

    alm_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_prev_we),
        .i_waddr (w_prev_wa),
        .i_wdata (w_prev_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_prev_rd)
    );

    alm_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (w_used_we),
        .i_waddr (w_used_wa),
        .i_wdata (w_used_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_used_rd)
    );

    // The value store is only written; nothing in the result reports a value.
    alm_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_waddr (w_val_wa),
        .i_wdata (w_val_wd),
        .i_raddr (w_raddr),
        .o_rdata ()
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_cnt    <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_free   <= IW'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_free   <= n_free;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act   <= n_act;
        r_slot  <= n_slot;
        r_bad   <= n_bad;
        r_val   <= n_val;
        r_a     <= n_a;
        r_n     <= n_n;
        r_p     <= n_p;
        r_nf    <= n_nf;
        r_st    <= n_st;
        r_res   <= n_res;
        r_ostat <= n_ostat;
        r_ores  <= n_ores;
        r_ohead <= n_ohead;
        r_otail <= n_otail;
        r_ofree <= n_ofree;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_head   = r_head;
        n_tail   = r_tail;
        n_free   = r_free;
        n_ovalid = r_ovalid;
        n_act    = r_act;
        n_slot   = r_slot;
        n_bad    = r_bad;
        n_val    = r_val;
        n_a      = r_a;
        n_n      = r_n;
        n_p      = r_p;
        n_nf     = r_nf;
        n_st     = r_st;
        n_res    = r_res;
        n_ostat  = r_ostat;
        n_ores   = r_ores;
        n_ohead  = r_ohead;
        n_otail  = r_otail;
        n_ofree  = r_ofree;

        o_ready   = 1'b0;
        w_raddr   = r_a;
        w_next_we = 1'b0;
        w_next_wa = r_a;
        w_next_wd = '0;
        w_prev_we = 1'b0;
        w_prev_wa = r_a;
        w_prev_wd = '0;
        w_used_we = 1'b0;
        w_used_wa = r_a;
        w_used_wd = 1'b0;
        w_val_we  = 1'b0;
        w_val_wa  = r_a;
        w_val_wd  = '0;

        // The receiver taking the waiting word frees the output register.
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                // Clearing pass: free chain i -> i+1, last slot and the
                // sentinel link to 0, only the sentinel is marked used.
                w_next_we = 1'b1;
                w_next_wa = r_cnt;
                w_next_wd = (r_cnt == IW'(SLOTS - 1) || r_cnt == '0) ? '0 : r_cnt + 1'b1;
                w_prev_we = 1'b1;
                w_prev_wa = r_cnt;
                w_used_we = 1'b1;
                w_used_wa = r_cnt;
                w_used_wd = (r_cnt == '0);
                w_val_we  = 1'b1;
                w_val_wa  = r_cnt;
                if (r_cnt == IW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_act   = t_action'(i_action);
                    n_slot  = w_slot_ext[IW-1:0];
                    n_bad   = (i_slot == '0) || (w_slot_ext >= EW'(SLOTS));
                    n_val   = w_val_ext[VALUE_BITS-1:0];
                    n_st    = ST_OK;
                    n_res   = '0;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = S_RDA;
                case (r_act)
                    ACT_PUSH_BACK: begin
                        n_a = r_free;
                        if (r_free == '0) begin
                            n_st    = ST_FULL;
                            n_state = S_DONE;
                        end
                    end
                    ACT_PUT_AFTER: begin
                        n_a = r_slot;
                        if (r_bad) begin
                            n_st    = ST_BADIDX;
                            n_state = S_DONE;
                        end else if (r_free == '0) begin
                            n_st    = ST_FULL;
                            n_state = S_DONE;
                        end
                    end
                    ACT_DROP_HEAD: begin
                        n_a = r_head;
                        if (r_head == '0) begin
                            n_st    = ST_EMPTY;
                            n_state = S_DONE;
                        end
                    end
                    ACT_DROP_TAIL: begin
                        n_a = r_tail;
                        if (r_tail == '0) begin
                            n_st    = ST_EMPTY;
                            n_state = S_DONE;
                        end
                    end
                    ACT_DROP_SLOT: begin
                        n_a = r_slot;
                        if (r_bad) begin
                            n_st    = ST_BADIDX;
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        // Unknown actions change nothing and report ok.
                        n_state = S_DONE;
                    end
                endcase
                w_raddr = n_a;
            end
            S_RDA: begin
                // Read data of slot r_a is now on the RAM outputs.
                n_n     = w_next_rd;
                n_p     = w_prev_rd;
                n_state = S_WR1;
                case (r_act)
                    ACT_PUSH_BACK: begin
                        if (w_used_rd) begin
                            n_st    = ST_CORRUPT;
                            n_state = S_DONE;
                        end
                    end
                    ACT_PUT_AFTER: begin
                        if (!w_used_rd) begin
                            n_st    = ST_MISSING;
                            n_state = S_DONE;
                        end else if (r_a == r_tail) begin
                            // Inserting after the tail is an insert at back.
                            n_act   = ACT_PUSH_BACK;
                            n_a     = r_free;
                            w_raddr = r_free;
                            n_state = S_RDA;
                        end else begin
                            w_raddr = r_free;
                            n_state = S_RDB;
                        end
                    end
                    ACT_DROP_SLOT: begin
                        if (!w_used_rd) begin
                            n_st    = ST_MISSING;
                            n_state = S_DONE;
                        end else if (r_a == r_head) begin
                            n_act   = ACT_DROP_HEAD;
                            n_state = S_RDA;
                        end else if (r_a == r_tail) begin
                            n_act   = ACT_DROP_TAIL;
                            n_state = S_RDA;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RDB: begin
                // Free head read for insert after.
                n_nf = w_next_rd;
                if (w_used_rd) begin
                    n_st    = ST_CORRUPT;
                    n_state = S_DONE;
                end else begin
                    n_state = S_WR1;
                end
            end
            S_WR1: begin
                n_state = S_WR2;
                case (r_act)
                    ACT_PUSH_BACK: begin
                        w_val_we  = 1'b1;
                        w_val_wd  = r_val;
                        w_next_we = 1'b1;
                        w_prev_we = 1'b1;
                        w_prev_wd = r_tail;
                        w_used_we = 1'b1;
                        w_used_wd = 1'b1;
                    end
                    ACT_PUT_AFTER: begin
                        w_val_we  = 1'b1;
                        w_val_wa  = r_free;
                        w_val_wd  = r_val;
                        w_prev_we = 1'b1;
                        w_prev_wa = r_free;
                        w_prev_wd = r_a;
                        w_used_we = 1'b1;
                        w_used_wa = r_free;
                        w_used_wd = 1'b1;
                        w_next_we = 1'b1;
                        w_next_wa = r_free;
                        w_next_wd = r_n;
                    end
                    ACT_DROP_HEAD: begin
                        w_prev_we = 1'b1;
                        w_used_we = 1'b1;
                        w_val_we  = 1'b1;
                        w_next_we = 1'b1;
                        w_next_wd = r_free;
                    end
                    ACT_DROP_TAIL: begin
                        w_next_we = (r_p != '0);
                        w_next_wa = r_p;
                        w_prev_we = 1'b1;
                        w_used_we = 1'b1;
                        w_val_we  = 1'b1;
                    end
                    ACT_DROP_SLOT: begin
                        w_prev_we = 1'b1;
                        w_prev_wa = r_n;
                        w_prev_wd = r_p;
                        w_next_we = 1'b1;
                        w_next_wa = r_p;
                        w_next_wd = r_n;
                        w_used_we = 1'b1;
                        w_val_we  = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_WR2: begin
                n_state = S_DONE;
                n_st    = ST_OK;
                case (r_act)
                    ACT_PUSH_BACK: begin
                        w_next_we = (r_tail != '0);
                        w_next_wa = r_tail;
                        w_next_wd = r_a;
                        n_free    = r_n;
                        n_tail    = r_a;
                        if (r_head == '0) begin
                            n_head = r_a;
                        end
                        n_res     = r_a;
                    end
                    ACT_PUT_AFTER: begin
                        w_next_we = 1'b1;
                        w_next_wd = r_free;
                        w_prev_we = (r_n != '0);
                        w_prev_wa = r_n;
                        w_prev_wd = r_free;
                        n_free    = r_nf;
                        n_res     = r_free;
                    end
                    ACT_DROP_HEAD: begin
                        w_prev_we = (r_n != '0);
                        w_prev_wa = r_n;
                        n_head    = r_n;
                        if (r_n == '0) begin
                            n_tail = '0;
                        end
                        n_free    = r_a;
                        n_res     = '0;
                    end
                    ACT_DROP_TAIL: begin
                        w_next_we = 1'b1;
                        w_next_wd = r_free;
                        n_tail    = r_p;
                        if (r_p == '0) begin
                            n_head = '0;
                        end
                        n_free    = r_a;
                        n_res     = r_p;
                    end
                    ACT_DROP_SLOT: begin
                        w_prev_we = 1'b1;
                        w_next_we = 1'b1;
                        w_next_wd = r_free;
                        n_free    = r_a;
                        n_res     = r_p;
                    end
                    default: begin
                    end
                endcase
            end
            S_DONE: begin
                // Wait here while the output register still holds a word.
                if (w_take_out) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_st;
                    n_ores   = (r_st == ST_OK) ? w_res_ext[SLOT_W-1:0] : '0;
                    n_ohead  = w_head_ext[SLOT_W-1:0];
                    n_otail  = w_tail_ext[SLOT_W-1:0];
                    n_ofree  = w_free_ext[SLOT_W-1:0];
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_ostat;
    assign o_result_slot = r_ores;
    assign o_head_slot   = r_ohead;
    assign o_tail_slot   = r_otail;
    assign o_free_slot   = r_ofree;

endmodule
